// ===== hdl/msc_pkg.sv =====
// Shared types, register map codes and constants of the media streaming coprocessor.
package msc_pkg;

  // Status byte revision field.
  localparam logic [2:0] REVISION = 3'd2;

  // Track header word that a valid audio file starts with.
  localparam logic [31:0] TRACK_MAGIC = 32'h4d53_5531;

  // Resume track value meaning that no resume point is stored.
  localparam logic [15:0] NO_RESUME = 16'hFFFF;

  // First sample offset in a track file, after the header and loop word.
  localparam logic [31:0] TRACK_START = 32'd8;

  // Width of a sample times volume product.
  localparam int unsigned PROD_W = 24;

  // Transaction kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_REPLY = 2'd3
  } kind_t;

  // Bus register indexes.
  localparam logic [2:0] REG_STATUS   = 3'd0;
  localparam logic [2:0] REG_DATA     = 3'd1;
  localparam logic [2:0] REG_SEEK1    = 3'd1;
  localparam logic [2:0] REG_SEEK0    = 3'd0;
  localparam logic [2:0] REG_SEEK2    = 3'd2;
  localparam logic [2:0] REG_SEEK3    = 3'd3;
  localparam logic [2:0] REG_TRACK_LO = 3'd4;
  localparam logic [2:0] REG_TRACK_HI = 3'd5;
  localparam logic [2:0] REG_VOLUME   = 3'd6;
  localparam logic [2:0] REG_CONTROL  = 3'd7;

  // Configuration register indexes.
  localparam logic CFG_DATA_PRESENT = 1'b0;
  localparam logic CFG_DATA_SIZE    = 1'b1;

  // One input transaction.
  typedef struct packed {
    kind_t              kind;
    logic [2:0]         reg_addr;
    logic [7:0]         write_data;
    logic [7:0]         data_byte;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               muted;
    logic               track_found;
    logic [31:0]        track_size;
    logic [31:0]        track_header;
    logic [31:0]        track_loop;
  } item_t;

  // Result of the state update, before the volume division.
  typedef struct packed {
    logic [7:0]              read_data;
    logic signed [PROD_W-1:0] left_prod;
    logic signed [PROD_W-1:0] right_prod;
    logic [31:0]             data_offset;
    logic [31:0]             audio_offset;
    logic                    open_request;
    logic [15:0]             open_track;
  } mid_t;

  // Identification string bytes for read registers two to seven.
  function automatic logic [7:0] ident_byte(input logic [2:0] addr);
    logic [7:0] b;
    unique case (addr)
      3'd2:    b = 8'h53; // S
      3'd3:    b = 8'h2D; // -
      3'd4:    b = 8'h4D; // M
      3'd5:    b = 8'h53; // S
      3'd6:    b = 8'h55; // U
      3'd7:    b = 8'h31; // 1
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/msc_scale.sv =====
// Signed division of a sample times volume product by 255, truncated toward zero.
module msc_scale
  import msc_pkg::*;
(
  input  logic signed [PROD_W-1:0] prod,
  output logic signed [15:0]       result
);

  logic              neg;
  logic [PROD_W-1:0] neg_prod;
  logic [PROD_W-2:0] mag;
  logic [PROD_W-1:0] approx_sum;
  logic [15:0]       q0;
  logic [PROD_W-1:0] q0_times;
  logic [PROD_W-1:0] rem;
  logic [15:0]       quot;

  // Take the magnitude so that truncation toward zero becomes a floor.
  assign neg      = prod[PROD_W-1];
  assign neg_prod = PROD_W'(-prod);
  assign mag      = neg ? neg_prod[PROD_W-2:0] : prod[PROD_W-2:0];

  // x/255 is x/256 * (1 + 1/256 + 1/65536 + ...); this estimate is low by at most one.
  assign approx_sum = {1'b0, mag} + PROD_W'(mag >> 8) + PROD_W'(mag >> 16);
  assign q0         = approx_sum[PROD_W-1:8];

  // One compare and add corrects the estimate.
  assign q0_times = {q0, 8'd0} - {8'd0, q0};
  assign rem      = {1'b0, mag} - q0_times;
  assign quot     = (rem >= PROD_W'(255)) ? q0 + 16'd1 : q0;

  // Restore the sign.
  assign result = neg ? $signed(-quot) : $signed(quot);

endmodule

// ===== hdl/msc_core.sv =====
// Register file, playback state and per-transaction update of the coprocessor.
module msc_core
  import msc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  item_t       item,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output mid_t        mid
);

  logic        data_present_r;
  logic [31:0] data_size_r;

  logic [31:0] seek_target_r,    seek_target_nxt;
  logic [31:0] data_pointer_r,   data_pointer_nxt;
  logic [31:0] play_pointer_r,   play_pointer_nxt;
  logic [31:0] loop_pointer_r,   loop_pointer_nxt;
  logic [15:0] track_number_r,   track_number_nxt;
  logic [7:0]  volume_level_r,   volume_level_nxt;
  logic [15:0] resume_track_r,   resume_track_nxt;
  logic [31:0] resume_pointer_r, resume_pointer_nxt;
  logic        error_flag_r,     error_flag_nxt;
  logic        play_flag_r,      play_flag_nxt;
  logic        repeat_flag_r,    repeat_flag_nxt;
  logic        track_valid_r,    track_valid_nxt;
  logic [31:0] track_length_r,   track_length_nxt;

  logic [15:0]              track_hi;
  logic [31:0]              loop_calc;
  logic                     header_ok;
  logic signed [PROD_W-1:0] vol_s;

  // Configuration registers: to be written by the user only while idle, unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_present_r <= 1'b0;
      data_size_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DATA_PRESENT: data_present_r <= cfg_data[0];
        CFG_DATA_SIZE:    data_size_r    <= cfg_data;
      endcase
    end
  end

  assign track_hi  = {item.write_data, track_number_r[7:0]};
  assign loop_calc = TRACK_START + {item.track_loop[29:0], 2'b00};
  assign header_ok = item.track_found && (item.track_size >= TRACK_START) &&
                     (item.track_header == TRACK_MAGIC);
  assign vol_s     = PROD_W'($signed({1'b0, volume_level_r}));

  // Next state and result for the transaction held in the input stage.
  always_comb begin
    seek_target_nxt    = seek_target_r;
    data_pointer_nxt   = data_pointer_r;
    play_pointer_nxt   = play_pointer_r;
    loop_pointer_nxt   = loop_pointer_r;
    track_number_nxt   = track_number_r;
    volume_level_nxt   = volume_level_r;
    resume_track_nxt   = resume_track_r;
    resume_pointer_nxt = resume_pointer_r;
    error_flag_nxt     = error_flag_r;
    play_flag_nxt      = play_flag_r;
    repeat_flag_nxt    = repeat_flag_r;
    track_valid_nxt    = track_valid_r;
    track_length_nxt   = track_length_r;
    mid.read_data      = 8'd0;
    mid.left_prod      = '0;
    mid.right_prod     = '0;
    mid.open_request   = 1'b0;

    unique case (item.kind)
      KIND_READ: begin
        unique case (item.reg_addr)
          REG_STATUS: begin
            mid.read_data = {2'b00, repeat_flag_r, play_flag_r, error_flag_r, REVISION};
          end
          REG_DATA: begin
            if (data_present_r && (data_pointer_r < data_size_r)) begin
              mid.read_data    = item.data_byte;
              data_pointer_nxt = data_pointer_r + 32'd1;
            end
          end
          default: begin
            mid.read_data = ident_byte(item.reg_addr);
          end
        endcase
      end
      KIND_WRITE: begin
        unique case (item.reg_addr)
          REG_SEEK0: seek_target_nxt[7:0]   = item.write_data;
          REG_SEEK1: seek_target_nxt[15:8]  = item.write_data;
          REG_SEEK2: seek_target_nxt[23:16] = item.write_data;
          REG_SEEK3: begin
            seek_target_nxt[31:24] = item.write_data;
            data_pointer_nxt       = {item.write_data, seek_target_r[23:0]};
          end
          REG_TRACK_LO: track_number_nxt[7:0] = item.write_data;
          REG_TRACK_HI: begin
            // Select a new track: stop, apply a resume point stored for it, ask for lookup.
            track_number_nxt = track_hi;
            play_flag_nxt    = 1'b0;
            repeat_flag_nxt  = 1'b0;
            track_valid_nxt  = 1'b0;
            mid.open_request = 1'b1;
            if (track_hi == resume_track_r) begin
              play_pointer_nxt   = resume_pointer_r;
              resume_track_nxt   = NO_RESUME;
              resume_pointer_nxt = '0;
            end else begin
              play_pointer_nxt = TRACK_START;
            end
          end
          REG_VOLUME: volume_level_nxt = item.write_data;
          REG_CONTROL: begin
            if (!error_flag_r) begin
              play_flag_nxt   = item.write_data[0];
              repeat_flag_nxt = item.write_data[1];
              if (!item.write_data[0] && item.write_data[2]) begin
                resume_track_nxt   = track_number_r;
                resume_pointer_nxt = play_pointer_r;
              end
            end
          end
        endcase
      end
      KIND_TICK: begin
        if (play_flag_r) begin
          priority if (!track_valid_r) begin
            play_flag_nxt = 1'b0;
          end else if (play_pointer_r >= track_length_r) begin
            // End of track: stop or go back to the loop point, silent this tick.
            if (!repeat_flag_r) begin
              play_flag_nxt    = 1'b0;
              play_pointer_nxt = TRACK_START;
            end else begin
              play_pointer_nxt = loop_pointer_r;
            end
          end else begin
            play_pointer_nxt = play_pointer_r + 32'd4;
            if (!item.muted) begin
              mid.left_prod  = PROD_W'(item.left_sample) * vol_s;
              mid.right_prod = PROD_W'(item.right_sample) * vol_s;
            end
          end
        end
      end
      KIND_REPLY: begin
        if (header_ok) begin
          loop_pointer_nxt = (loop_calc > item.track_size) ? TRACK_START : loop_calc;
          track_length_nxt = item.track_size;
          error_flag_nxt   = 1'b0;
          track_valid_nxt  = 1'b1;
        end else begin
          track_valid_nxt = 1'b0;
          error_flag_nxt  = 1'b1;
        end
      end
    endcase

    mid.data_offset  = data_pointer_nxt;
    mid.audio_offset = play_pointer_nxt;
    mid.open_track   = track_number_nxt;
  end

  // State registers, updated once per transaction leaving the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seek_target_r    <= '0;
      data_pointer_r   <= '0;
      play_pointer_r   <= '0;
      loop_pointer_r   <= '0;
      track_number_r   <= '0;
      volume_level_r   <= '0;
      resume_track_r   <= NO_RESUME;
      resume_pointer_r <= '0;
      error_flag_r     <= 1'b0;
      play_flag_r      <= 1'b0;
      repeat_flag_r    <= 1'b0;
      track_valid_r    <= 1'b0;
      track_length_r   <= '0;
    end else if (en) begin
      seek_target_r    <= seek_target_nxt;
      data_pointer_r   <= data_pointer_nxt;
      play_pointer_r   <= play_pointer_nxt;
      loop_pointer_r   <= loop_pointer_nxt;
      track_number_r   <= track_number_nxt;
      volume_level_r   <= volume_level_nxt;
      resume_track_r   <= resume_track_nxt;
      resume_pointer_r <= resume_pointer_nxt;
      error_flag_r     <= error_flag_nxt;
      play_flag_r      <= play_flag_nxt;
      repeat_flag_r    <= repeat_flag_nxt;
      track_valid_r    <= track_valid_nxt;
      track_length_r   <= track_length_nxt;
    end
  end

  // An open track is never in error: a reply sets one and clears the other.
  a_valid_not_error: assert property (@(posedge clk) disable iff (!rst_n)
    track_valid_r |-> !error_flag_r)
    else $error("track open while error flag is set");

  // Every play position is a whole stereo sample frame.
  a_pointer_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    play_pointer_r[1:0] == 2'b00)
    else $error("play pointer not frame aligned");

  // The data pointer moves only on a data read or a write of the top seek byte.
  a_data_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(en && ((item.kind == KIND_READ && item.reg_addr == REG_DATA) ||
             (item.kind == KIND_WRITE && item.reg_addr == REG_SEEK3)))
    |=> $stable(data_pointer_r))
    else $error("data pointer changed without a data read or seek");

  // A lookup is requested only by the write that completes the track number.
  a_open_source: assert property (@(posedge clk) disable iff (!rst_n)
    mid.open_request |-> (item.kind == KIND_WRITE && item.reg_addr == REG_TRACK_HI))
    else $error("open request from a transaction other than a track write");

endmodule

// ===== hdl/media_streaming_coprocessor.sv =====
// Top level of the media streaming coprocessor: input, update and output stages.
//
// Each input transaction (bus read, bus write, sample tick or track reply) gives
// exactly one result transaction. The block takes one transaction per clock
// cycle when the result side keeps up. A result passes through the input,
// middle and output registers in turn: the transaction is loaded into the
// input register at the accepting edge, the state update and sample-by-volume
// multiply are captured in the middle register, and the division of the
// products by 255 is captured in the output register, whose contents are
// presented on the outputs. Status, data pointer and play pointer are updated
// as a transaction leaves the input register, so back-to-back transactions
// always see the effect of the one before. The configuration port is always
// ready and must be written only while no transaction is in flight.
module media_streaming_coprocessor
  import msc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [2:0]         in_reg_addr,
  input  logic [7:0]         in_write_data,
  input  logic [7:0]         in_data_byte,
  input  logic signed [15:0] in_left_sample,
  input  logic signed [15:0] in_right_sample,
  input  logic               in_muted,
  input  logic               in_track_found,
  input  logic [31:0]        in_track_size,
  input  logic [31:0]        in_track_header,
  input  logic [31:0]        in_track_loop,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_read_data,
  output logic signed [15:0] out_left_out,
  output logic signed [15:0] out_right_out,
  output logic [31:0]        out_data_offset,
  output logic [31:0]        out_audio_offset,
  output logic               out_open_request,
  output logic [15:0]        out_open_track,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  logic  s2_valid_r, s2_valid_nxt;
  mid_t  s2_mid_r;
  logic  out_valid_r, out_valid_nxt;
  mid_t  core_mid;

  logic               in_accept;
  logic               s1_adv;
  logic               s2_adv;
  logic               s2_free;
  logic signed [15:0] left_scaled;
  logic signed [15:0] right_scaled;

  logic signed [15:0] out_left_r;
  logic signed [15:0] out_right_r;
  logic [7:0]         out_read_r;
  logic [31:0]        out_data_off_r;
  logic [31:0]        out_audio_off_r;
  logic               out_open_req_r;
  logic [15:0]        out_open_trk_r;

  // Pipeline flow control: each stage moves on when the next one is free.
  assign s2_adv    = s2_valid_r && (!out_valid_r || out_ready);
  assign s2_free   = !s2_valid_r || s2_adv;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s1_adv);
  assign s2_valid_nxt  = s1_adv || (s2_valid_r && !s2_adv);
  assign out_valid_nxt = s2_adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.kind         <= kind_t'(in_kind);
      s1_item_r.reg_addr     <= in_reg_addr;
      s1_item_r.write_data   <= in_write_data;
      s1_item_r.data_byte    <= in_data_byte;
      s1_item_r.left_sample  <= in_left_sample;
      s1_item_r.right_sample <= in_right_sample;
      s1_item_r.muted        <= in_muted;
      s1_item_r.track_found  <= in_track_found;
      s1_item_r.track_size   <= in_track_size;
      s1_item_r.track_header <= in_track_header;
      s1_item_r.track_loop   <= in_track_loop;
    end
  end

  // State update and sample multiply.
  msc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_adv),
    .item      (s1_item_r),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mid       (core_mid)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_mid_r <= core_mid;
    end
  end

  // Volume division, one unit for each channel.
  msc_scale u_scale_left (
    .prod   (s2_mid_r.left_prod),
    .result (left_scaled)
  );

  msc_scale u_scale_right (
    .prod   (s2_mid_r.right_prod),
    .result (right_scaled)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_read_r      <= s2_mid_r.read_data;
      out_left_r      <= left_scaled;
      out_right_r     <= right_scaled;
      out_data_off_r  <= s2_mid_r.data_offset;
      out_audio_off_r <= s2_mid_r.audio_offset;
      out_open_req_r  <= s2_mid_r.open_request;
      out_open_trk_r  <= s2_mid_r.open_track;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_r;
  assign out_left_out     = out_left_r;
  assign out_right_out    = out_right_r;
  assign out_data_offset  = out_data_off_r;
  assign out_audio_offset = out_audio_off_r;
  assign out_open_request = out_open_req_r;
  assign out_open_track   = out_open_trk_r;

endmodule
